// ===== rtl/core/acm_pkg.sv =====
`timescale 1ns / 1ps
package acm_pkg;
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_START = 2'd2,
        CMD_STEP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_STOP   = 2'd1,
        ST_DIVZ   = 2'd2,
        ST_HALTED = 2'd3
    } status_t;

    localparam int unsigned OP_LOAD  = 0;
    localparam int unsigned OP_STORE = 1;
    localparam int unsigned OP_ADD   = 2;
    localparam int unsigned OP_MUL   = 3;
    localparam int unsigned OP_DIV   = 4;
    localparam int unsigned OP_SUB   = 5;
    localparam int unsigned OP_JMP   = 6;
    localparam int unsigned OP_JZ    = 7;
    localparam int unsigned OP_JP    = 8;
    localparam int unsigned OP_JN    = 9;
    localparam int unsigned OP_PRINT = 10;
    localparam int unsigned OP_INPUT = 11;
    localparam int unsigned OP_STOP  = 12;
endpackage

// ===== rtl/core/acm_ram.sv =====
`timescale 1ns / 1ps
module acm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/accumulator_machine_core.sv =====
`timescale 1ns / 1ps
// Multiply and divide run on a bit-serial shift-add / restoring divide unit.
// One beat at a time: the next beat is taken only after the result has left.
// Reset: aresetn clears control and pc/acc, then a clearing pass writes zero to
// all MEM_WORDS words before s_ready rises.
module accumulator_machine_core #(
    parameter int MEM_WORDS = 128,
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [6:0]  s_address,
    input  logic signed [31:0] s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_read_data,
    output logic        m_out_valid,
    output logic signed [31:0] m_out_value,
    output logic        m_input_taken,
    output logic        m_halted,
    output logic [7:0]  m_program_counter,
    output logic signed [31:0] m_accumulator,
    output logic [1:0]  m_status
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2,
        S_RDW = 4'd3, S_OPC = 4'd4, S_OPA = 4'd5, S_MEM = 4'd6, S_EXEC = 4'd7,
        S_MUL = 4'd8, S_DIV = 4'd9, S_OUT = 4'd10, S_FIN = 4'd11;

    logic [3:0]    state_reg;
    logic [AW:0]   clr_reg;
    logic [1:0]    cmd_reg;
    logic [AW-1:0] addr_reg;
    logic [W-1:0]  data_reg;
    logic [AW:0]   pc_reg;
    logic [W-1:0]  acc_reg;
    logic          stopped_reg;
    logic [W-1:0]  opw_reg;
    logic [AW-1:0] opnd_reg;
    logic [W-1:0]  m_reg;
    // serial unit: a = shifting multiplicand/dividend, b = multiplier/divisor
    logic [W-1:0]  sa_reg, sb_reg, sp_reg;
    logic [CW-1:0] cnt_reg;
    logic          qneg_reg;

    logic          o_valid_reg;
    logic [31:0]   o_rd_reg, o_val_reg, o_acc_reg;
    logic          o_ov_reg, o_it_reg, o_h_reg;
    logic [7:0]    o_pc_reg;
    logic [1:0]    o_st_reg;

    // RAM ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [W-1:0]  wdata, rdata;

    acm_ram #(.WIDTH(W), .DEPTH(MEM_WORDS)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [31:0] ext32(input logic [W-1:0] v);
        logic [63:0] t;
        t = 64'(signed'(v));
        return t[31:0];
    endfunction

    function automatic logic [W-1:0] from32(input logic [31:0] v);
        logic [63:0] t;
        t = 64'(signed'(v));
        return t[W-1:0];
    endfunction

    logic [W-1:0] opnd_full;
    logic         in_range;
    logic [W:0]   dsub;
    logic [W-1:0] rem_sh, qabs;
    logic         opneg;
    logic [W-1:0] code;

    assign opnd_full = rdata;
    assign in_range  = !pc_reg[AW];
    assign opneg     = opw_reg[W-1];
    assign code      = opneg ? W'(acm_pkg::OP_STOP) : opw_reg;
    // restoring divide: sp = remainder, sa = dividend shifting into quotient
    assign rem_sh    = {sp_reg[W-2:0], sa_reg[W-1]};
    assign dsub      = {1'b0, rem_sh} - {1'b0, sb_reg};
    assign qabs      = sa_reg;

    assign s_ready = (state_reg == S_IDLE) && !o_valid_reg;
    assign m_valid = o_valid_reg;
    assign m_read_data = o_rd_reg;
    assign m_out_valid = o_ov_reg;
    assign m_out_value = o_val_reg;
    assign m_input_taken = o_it_reg;
    assign m_halted = o_h_reg;
    assign m_program_counter = o_pc_reg;
    assign m_accumulator = o_acc_reg;
    assign m_status = o_st_reg;

    // memory port muxing
    always_comb begin
        we = 1'b0;
        waddr = addr_reg;
        wdata = data_reg;
        raddr = addr_reg;
        unique case (state_reg)
            S_CLEAR: begin
                we = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = '0;
            end
            S_RD: begin
                if (cmd_reg == acm_pkg::CMD_WRITE) begin
                    we = 1'b1;
                end
                raddr = (cmd_reg == acm_pkg::CMD_READ) ? addr_reg : pc_reg[AW-1:0];
            end
            S_RDW: raddr = pc_reg[AW-1:0] + AW'(1);
            S_OPC: raddr = pc_reg[AW-1:0] + AW'(1);
            S_OPA: raddr = opnd_full[AW-1:0];
            S_EXEC: begin
                waddr = opnd_reg;
                if (code == W'(acm_pkg::OP_STORE)) begin
                    we = 1'b1;
                    wdata = acc_reg;
                end else if (code == W'(acm_pkg::OP_INPUT)) begin
                    we = 1'b1;
                    wdata = data_reg;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            pc_reg <= '0;
            acc_reg <= '0;
            stopped_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (o_valid_reg && m_ready) begin
                o_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(MEM_WORDS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg <= s_cmd;
                        addr_reg <= AW'(s_address);
                        data_reg <= from32(s_data);
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    o_rd_reg <= '0; o_ov_reg <= 1'b0; o_val_reg <= '0;
                    o_it_reg <= 1'b0; o_st_reg <= acm_pkg::ST_OK;
                    if (cmd_reg == acm_pkg::CMD_STEP) begin
                        if (stopped_reg || !in_range) begin
                            o_st_reg <= acm_pkg::ST_HALTED;
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_OPC;
                        end
                    end else if (cmd_reg == acm_pkg::CMD_START) begin
                        pc_reg <= {1'b0, addr_reg};
                        acc_reg <= '0;
                        stopped_reg <= 1'b0;
                        state_reg <= S_FIN;
                    end else if (cmd_reg == acm_pkg::CMD_READ) begin
                        state_reg <= S_RDW;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_RDW: begin
                    o_rd_reg <= ext32(rdata);
                    state_reg <= S_FIN;
                end
                S_OPC: begin
                    opw_reg <= rdata;
                    state_reg <= S_OPA;
                end
                S_OPA: begin
                    opnd_reg <= opnd_full[AW-1:0];
                    state_reg <= S_MEM;
                end
                S_MEM: begin
                    m_reg <= rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    pc_reg <= pc_reg + (AW+1)'(2);
                    state_reg <= S_FIN;
                    case (code)
                        W'(acm_pkg::OP_LOAD): acc_reg <= m_reg;
                        W'(acm_pkg::OP_STORE): ;
                        W'(acm_pkg::OP_ADD): acc_reg <= acc_reg + m_reg;
                        W'(acm_pkg::OP_SUB): acc_reg <= acc_reg - m_reg;
                        W'(acm_pkg::OP_MUL): begin
                            sa_reg <= acc_reg;
                            sb_reg <= m_reg;
                            sp_reg <= '0;
                            cnt_reg <= CW'(W);
                            state_reg <= S_MUL;
                        end
                        W'(acm_pkg::OP_DIV): begin
                            if (m_reg == '0) begin
                                o_st_reg <= acm_pkg::ST_DIVZ;
                            end else begin
                                sa_reg <= acc_reg[W-1] ? -acc_reg : acc_reg;
                                sb_reg <= m_reg[W-1] ? -m_reg : m_reg;
                                sp_reg <= '0;
                                qneg_reg <= acc_reg[W-1] ^ m_reg[W-1];
                                cnt_reg <= CW'(W);
                                state_reg <= S_DIV;
                            end
                        end
                        W'(acm_pkg::OP_JMP): pc_reg <= {1'b0, opnd_reg};
                        W'(acm_pkg::OP_JZ):
                            if (acc_reg == '0) pc_reg <= {1'b0, opnd_reg};
                        W'(acm_pkg::OP_JP):
                            if (acc_reg != '0 && !acc_reg[W-1]) pc_reg <= {1'b0, opnd_reg};
                        W'(acm_pkg::OP_JN):
                            if (acc_reg[W-1]) pc_reg <= {1'b0, opnd_reg};
                        W'(acm_pkg::OP_PRINT): begin
                            o_ov_reg <= 1'b1;
                            o_val_reg <= ext32(m_reg);
                        end
                        W'(acm_pkg::OP_INPUT): o_it_reg <= 1'b1;
                        default: begin
                            stopped_reg <= 1'b1;
                            o_st_reg <= acm_pkg::ST_STOP;
                        end
                    endcase
                end
                // shift-add multiply, one multiplier bit per cycle
                S_MUL: begin
                    if (cnt_reg == '0) begin
                        acc_reg <= sp_reg;
                        state_reg <= S_FIN;
                    end else begin
                        if (sb_reg[0]) sp_reg <= sp_reg + sa_reg;
                        sa_reg <= {sa_reg[W-2:0], 1'b0};
                        sb_reg <= {1'b0, sb_reg[W-1:1]};
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (cnt_reg == '0) begin
                        acc_reg <= qneg_reg ? -qabs : qabs;
                        state_reg <= S_FIN;
                    end else begin
                        if (!dsub[W]) begin
                            sp_reg <= dsub[W-1:0];
                            sa_reg <= {sa_reg[W-2:0], 1'b1};
                        end else begin
                            sp_reg <= rem_sh;
                            sa_reg <= {sa_reg[W-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_FIN: begin
                    o_h_reg <= stopped_reg || pc_reg[AW];
                    o_pc_reg <= 8'(pc_reg);
                    o_acc_reg <= ext32(acc_reg);
                    o_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("ready while busy");
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= (AW+1)'(MEM_WORDS + 1)) else $error("pc out of range");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_accumulator))
        else $error("result dropped");
    a_halt_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (m_halted == (stopped_reg || pc_reg[AW])))
        else $error("halted mismatch");
endmodule

// ===== tb/sv/accumulator_machine_core_test.sv =====
`timescale 1ns / 1ps
module accumulator_machine_core_test;

    localparam int MEM_WORDS = 128;
    localparam int N_ITEMS = 1450;

    // one result beat, unpacked
    typedef struct {
        logic signed [31:0] read_data;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               input_taken;
        logic               halted;
        logic [7:0]         pc;
        logic signed [31:0] acc;
        acm_pkg::status_t   status;
    } acm_result_t;

    // Machine state mirror plus the queue of expected result beats
    class acm_scoreboard;
        logic [31:0] mem [MEM_WORDS];
        logic [7:0]  pc;
        logic [31:0] acc;
        bit          stopped;
        acm_result_t pending[$];
        int          errors;

        function void clear();
            foreach (mem[i]) mem[i] = '0;
            pc = '0;
            acc = '0;
            stopped = 0;
            pending.delete();
            errors = 0;
        endfunction

        function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma, mb, q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        // Execute one input beat on the mirror and queue its result
        function void note_input(acm_pkg::cmd_t cmd, logic [6:0] addr, logic [31:0] data);
            acm_result_t r;
            logic [31:0] opw, m;
            logic [6:0]  opnd;
            logic [7:0]  nxt;
            r.read_data = '0;
            r.out_valid = 1'b0;
            r.out_value = '0;
            r.input_taken = 1'b0;
            r.status = acm_pkg::ST_OK;
            case (cmd)
                acm_pkg::CMD_WRITE: mem[addr] = data;
                acm_pkg::CMD_READ:  r.read_data = mem[addr];
                acm_pkg::CMD_START: begin
                    pc = {1'b0, addr};
                    acc = '0;
                    stopped = 0;
                end
                default: begin
                    if (stopped || pc >= MEM_WORDS) begin
                        r.status = acm_pkg::ST_HALTED;
                    end else begin
                        opw = mem[pc[6:0]];
                        opnd = mem[pc[6:0] + 7'd1][6:0];
                        m = mem[opnd];
                        nxt = pc + 8'd2;
                        if (opw[31] || opw > acm_pkg::OP_STOP) opw = acm_pkg::OP_STOP;
                        case (opw)
                            acm_pkg::OP_LOAD:  acc = m;
                            acm_pkg::OP_STORE: mem[opnd] = acc;
                            acm_pkg::OP_ADD:   acc = acc + m;
                            acm_pkg::OP_MUL:   acc = acc * m;
                            acm_pkg::OP_DIV: begin
                                if (m == 0) r.status = acm_pkg::ST_DIVZ;
                                else acc = quotient(acc, m);
                            end
                            acm_pkg::OP_SUB:   acc = acc - m;
                            acm_pkg::OP_JMP:   nxt = {1'b0, opnd};
                            acm_pkg::OP_JZ:    if (acc == 0) nxt = {1'b0, opnd};
                            acm_pkg::OP_JP:    if (acc != 0 && !acc[31]) nxt = {1'b0, opnd};
                            acm_pkg::OP_JN:    if (acc[31]) nxt = {1'b0, opnd};
                            acm_pkg::OP_PRINT: begin
                                r.out_valid = 1;
                                r.out_value = m;
                            end
                            acm_pkg::OP_INPUT: begin
                                mem[opnd] = data;
                                r.input_taken = 1;
                            end
                            default: begin
                                stopped = 1;
                                r.status = acm_pkg::ST_STOP;
                            end
                        endcase
                        pc = nxt;
                    end
                end
            endcase
            r.halted = stopped || pc >= MEM_WORDS;
            r.pc = pc;
            r.acc = acc;
            pending.push_back(r);
        endfunction

        function void check_result(acm_result_t got);
            acm_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat pc=%0d", $time, got.pc);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.read_data !== e.read_data) begin
                $display("%0t: read_data exp %0d got %0d", $time, e.read_data, got.read_data);
                errors++;
            end
            if (got.out_valid !== e.out_valid) begin
                $display("%0t: out_valid exp %0d got %0d", $time, e.out_valid, got.out_valid);
                errors++;
            end
            if (got.out_value !== e.out_value) begin
                $display("%0t: out_value exp %0d got %0d", $time, e.out_value, got.out_value);
                errors++;
            end
            if (got.input_taken !== e.input_taken) begin
                $display("%0t: input_taken exp %0d got %0d", $time, e.input_taken,
                         got.input_taken);
                errors++;
            end
            if (got.halted !== e.halted) begin
                $display("%0t: halted exp %0d got %0d", $time, e.halted, got.halted);
                errors++;
            end
            if (got.pc !== e.pc) begin
                $display("%0t: program_counter exp %0d got %0d", $time, e.pc, got.pc);
                errors++;
            end
            if (got.acc !== e.acc) begin
                $display("%0t: accumulator exp %0d got %0d", $time, e.acc, got.acc);
                errors++;
            end
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [6:0]         s_address;
    logic signed [31:0] s_data;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_read_data;
    logic               m_out_valid;
    logic signed [31:0] m_out_value;
    logic               m_input_taken;
    logic               m_halted;
    logic [7:0]         m_program_counter;
    logic signed [31:0] m_accumulator;
    logic [1:0]         m_status;

    accumulator_machine_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_address(s_address), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_read_data(m_read_data), .m_out_valid(m_out_valid),
        .m_out_value(m_out_value), .m_input_taken(m_input_taken),
        .m_halted(m_halted), .m_program_counter(m_program_counter),
        .m_accumulator(m_accumulator), .m_status(m_status)
    );

    acm_scoreboard sb;
    bit            hold_sink;
    int            n_sent;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("accumulator_machine_core_test failed");
        $finish;
    end

    // Send one beat, then the random gap before the next one
    task automatic send(acm_pkg::cmd_t cmd, logic [6:0] addr, logic [31:0] data, int gap);
        s_valid <= 1;
        s_cmd <= cmd;
        s_address <= addr;
        s_data <= data;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(cmd, addr, data);
        n_sent++;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic int draw_gap(bit busy);
        return busy ? $urandom_range(0, 11) : 0;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_opcode();
        if ($urandom_range(0, 19) == 0) return rand_word();
        return $urandom_range(0, acm_pkg::OP_STOP);
    endfunction

    task automatic write_word(logic [6:0] a, logic [31:0] d, bit busy);
        send(acm_pkg::CMD_WRITE, a, d, draw_gap(busy));
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // Result side: random ready, with an occasional long hold
    initial begin
        acm_result_t got;
        int          n;
        m_ready = 0;
        wait (aresetn);
        forever begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            if (hold_sink || n > 0) begin
                m_ready <= 0;
                while (hold_sink) @(posedge aclk);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.read_data = m_read_data;
                got.out_valid = m_out_valid;
                got.out_value = m_out_value;
                got.input_taken = m_input_taken;
                got.halted = m_halted;
                got.pc = m_program_counter;
                got.acc = m_accumulator;
                got.status = acm_pkg::status_t'(m_status);
                sb.check_result(got);
            end
        end
    end

    initial begin
        int          steps;
        bit          busy;
        bit          held;
        logic [6:0]  base;
        sb = new();
        sb.clear();
        aresetn = 0;
        s_valid = 0;
        s_cmd = acm_pkg::CMD_WRITE;
        s_address = '0;
        s_data = '0;
        hold_sink = 0;
        held = 0;
        n_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: memory corners, every opcode but LOAD once, and out-of-range opcodes
        send(acm_pkg::CMD_READ, 7'd127, '0, 0);
        send(acm_pkg::CMD_STEP, 7'd0, '0, 0);
        write_word(7'd100, 32'h8000_0000, 0);
        write_word(7'd101, 32'hffff_ffff, 0);
        write_word(7'd102, 32'd0, 0);
        write_word(7'd103, 32'h7fff_ffff, 0);
        send(acm_pkg::CMD_READ, 7'd101, '0, 0);
        for (int op = 0; op <= 14; op++) begin
            write_word(7'd0, (op == 14) ? 32'hffff_fff0 : op, 0);
            write_word(7'd1, (op == acm_pkg::OP_DIV) ? 32'd102 : 32'd100, 0);
            send(acm_pkg::CMD_START, 7'd0, '0, 0);
            if (op != acm_pkg::OP_LOAD) send(acm_pkg::CMD_STEP, 7'd0, 32'h5a5a_a5a5, 0);
        end
        // Divide overflow: min / -1
        write_word(7'd0, acm_pkg::OP_LOAD, 0);
        write_word(7'd1, 32'd100, 0);
        write_word(7'd2, acm_pkg::OP_DIV, 0);
        write_word(7'd3, 32'd101, 0);
        send(acm_pkg::CMD_START, 7'd0, '0, 0);
        send(acm_pkg::CMD_STEP, 7'd0, '0, 0);
        send(acm_pkg::CMD_STEP, 7'd0, '0, 0);
        // Operand fetch wraps at the top word, then pc runs off the end
        write_word(7'd127, acm_pkg::OP_LOAD, 0);
        write_word(7'd0, 32'hffff_ff83, 0);
        send(acm_pkg::CMD_START, 7'd127, '0, 0);
        send(acm_pkg::CMD_STEP, 7'd0, '0, 0);
        send(acm_pkg::CMD_STEP, 7'd0, '0, 0);
        // Sender pauses until the block is empty
        s_valid <= 0;
        wait_drained();

        // Random: mostly small programs, then runs of steps
        while (n_sent < N_ITEMS) begin
            base = 7'($urandom_range(0, 127));
            for (int k = 0; k < 6; k++) begin
                busy = $urandom_range(0, 2) == 0;
                write_word(base + 7'(2 * k), rand_opcode(), busy);
                write_word(base + 7'(2 * k + 1),
                           ($urandom_range(0, 9) == 0) ? rand_word() : $urandom_range(0, 127),
                           busy);
            end
            for (int k = 0; k < 4; k++) begin
                busy = $urandom_range(0, 2) == 0;
                write_word(7'($urandom_range(0, 127)), rand_word(), busy);
            end
            send(acm_pkg::CMD_START, base, rand_word(), draw_gap(1));
            steps = $urandom_range(4, 14);
            for (int k = 0; k < steps; k++) begin
                busy = $urandom_range(0, 2) == 0;
                if ($urandom_range(0, 15) == 0)
                    send(acm_pkg::CMD_READ, 7'($urandom_range(0, 127)), rand_word(),
                         draw_gap(busy));
                else
                    send(acm_pkg::CMD_STEP, 7'($urandom_range(0, 127)), rand_word(),
                         draw_gap(busy));
            end
            // Back-pressure: stall the sink while steps keep coming
            if (!held || $urandom_range(0, 25) == 0) begin
                held = 1;
                fork
                    begin
                        hold_sink = 1;
                        repeat (300) @(posedge aclk);
                        hold_sink = 0;
                    end
                    repeat (10) send(acm_pkg::CMD_STEP, '0, rand_word(), 0);
                join
                // Sender pauses until the block is empty
                s_valid <= 0;
                wait_drained();
            end
        end
        s_valid <= 0;
        wait_drained();
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("accumulator_machine_core_test passed");
        else
            $display("accumulator_machine_core_test failed");
        $finish;
    end
endmodule
